>>> hdl/wfsm_pkg.sv
`default_nettype none

package wfsm_pkg;

    localparam int MEM_PORT_W = 48;
    localparam int PROD_W     = 52;
    localparam int RATE_W     = 16;

    localparam logic [31:0] WIN_LEN_RESET = 32'd1000000;
    localparam logic [19:0] USEC_PER_SEC  = 20'd1000000;
    localparam logic [15:0] RATE_MAX      = 16'hFFFF;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [5:0] STEPS_RATE = 6'd16;
    localparam logic [5:0] STEPS_MEAN = 6'd32;

    typedef enum logic {
        OP_RESTART = 1'b0,
        OP_FRAME   = 1'b1
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [63:0] timestamp_us;
        logic [31:0] fill_time_us;
        logic [31:0] present_time_us;
        logic [47:0] mem_in_use;
        logic [47:0] video_mem_in_use;
    } t_cmd;

    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] low;
        logic [63:0] divisor;
        logic [5:0]  steps;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quot;
    } t_div_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SAT,
        ST_RATE,
        ST_FILL,
        ST_PRES,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

>>> hdl/wfsm_if.sv
`default_nettype none

interface wfsm_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [63:0] timestamp_us;
    logic [31:0] fill_time_us;
    logic [31:0] present_time_us;
    logic [47:0] mem_in_use;
    logic [47:0] video_mem_in_use;

    modport source (
        output valid, kind, timestamp_us, fill_time_us, present_time_us,
               mem_in_use, video_mem_in_use,
        input  ready
    );
    modport sink (
        input  valid, kind, timestamp_us, fill_time_us, present_time_us,
               mem_in_use, video_mem_in_use,
        output ready
    );
endinterface

interface wfsm_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] mem_current;
    logic [47:0] video_mem_current;
    logic [47:0] mem_peak;
    logic [47:0] video_mem_peak;
    logic [31:0] fill_time_peak;
    logic [31:0] present_time_peak;
    logic [15:0] frame_rate;
    logic [31:0] fill_time_avg;
    logic [31:0] present_time_avg;
    logic        stats_valid;
    logic        window_done;

    modport source (
        output valid, mem_current, video_mem_current, mem_peak, video_mem_peak,
               fill_time_peak, present_time_peak, frame_rate, fill_time_avg,
               present_time_avg, stats_valid, window_done,
        input  ready
    );
    modport sink (
        input  valid, mem_current, video_mem_current, mem_peak, video_mem_peak,
               fill_time_peak, present_time_peak, frame_rate, fill_time_avg,
               present_time_avg, stats_valid, window_done,
        output ready
    );
endinterface

interface wfsm_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> hdl/wfsm_front.sv
`default_nettype none

module wfsm_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    wfsm_in_if.sink        i_in,
    output logic           o_cmd_valid,
    input  wire            i_cmd_ready,
    output wfsm_pkg::t_cmd o_cmd
);
    import wfsm_pkg::*;

    t_cmd            r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0] r_count, n_count;
    logic            push, pop;
    t_cmd            in_cmd;

    always_comb begin
        in_cmd.op               = i_in.kind ? OP_FRAME : OP_RESTART;
        in_cmd.timestamp_us     = i_in.timestamp_us;
        in_cmd.fill_time_us     = i_in.fill_time_us;
        in_cmd.present_time_us  = i_in.present_time_us;
        in_cmd.mem_in_use       = i_in.mem_in_use;
        in_cmd.video_mem_in_use = i_in.video_mem_in_use;
    end

    assign i_in.ready  = (r_count != Q_CW'(Q_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign push        = i_in.valid && i_in.ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wr_ptr = push ? Q_AW'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = pop  ? Q_AW'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = Q_CW'(r_count + 1'b1);
        end else if (pop && !push) begin
            n_count = Q_CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

>>> hdl/wfsm_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller guarantees the
// initial remainder is below the divisor, so the quotient fits in steps bits.
module wfsm_div (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wfsm_pkg::t_div_req i_req,
    output wfsm_pkg::t_div_stat o_stat
);
    import wfsm_pkg::*;

    logic [63:0] r_rem, n_rem;
    logic [31:0] r_low, n_low;
    logic [63:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] trial;
    logic        ge;

    always_comb begin
        trial = {r_rem, r_low[31]};
        ge    = (trial >= {1'b0, r_div});
        n_rem = ge ? 64'(trial - {1'b0, r_div}) : trial[63:0];
        n_low = {r_low[30:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_req.rem;
            r_low <= i_req.low;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_low <= n_low;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.quot = r_low;

endmodule

`default_nettype wire

>>> hdl/wfsm_back.sv
`default_nettype none

module wfsm_back #(
    parameter int MEM_COUNT_BITS = 48
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire  [31:0]    i_win_len,
    input  wire            i_cmd_valid,
    output logic           o_cmd_ready,
    input  wfsm_pkg::t_cmd i_cmd,
    wfsm_out_if.source     o_out
);
    import wfsm_pkg::*;

    localparam int MW = (MEM_COUNT_BITS < MEM_PORT_W) ? MEM_COUNT_BITS : MEM_PORT_W;

    typedef struct packed {
        logic [47:0] mem_current;
        logic [47:0] video_mem_current;
        logic [47:0] mem_peak;
        logic [47:0] video_mem_peak;
        logic [31:0] fill_time_peak;
        logic [31:0] present_time_peak;
        logic [15:0] frame_rate;
        logic [31:0] fill_time_avg;
        logic [31:0] present_time_avg;
        logic        stats_valid;
        logic        window_done;
    } t_result;

    t_state              r_state, n_state;
    logic [63:0]         r_win_start, n_win_start;
    logic [63:0]         r_fill_sum, n_fill_sum;
    logic [63:0]         r_pres_sum, n_pres_sum;
    logic [31:0]         r_frames, n_frames;
    logic [MW-1:0]       r_mem_last, n_mem_last;
    logic [MW-1:0]       r_vmem_last, n_vmem_last;
    logic [MW-1:0]       r_mem_high, n_mem_high;
    logic [MW-1:0]       r_vmem_high, n_vmem_high;
    logic [31:0]         r_fill_high, n_fill_high;
    logic [31:0]         r_pres_high, n_pres_high;
    logic [RATE_W-1:0]   r_rate, n_rate;
    logic [31:0]         r_fill_mean, n_fill_mean;
    logic [31:0]         r_pres_mean, n_pres_mean;
    logic                r_valid_flag, n_valid_flag;
    logic [63:0]         r_now, n_now;
    logic [63:0]         r_elapsed, n_elapsed;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic                r_out_valid, n_out_valid;
    t_result             r_out, n_out;

    logic                slot_free;
    logic                load_out;
    logic                done_bit;
    logic [MW-1:0]       mem_in, vmem_in;
    logic [31:0]         frames_nx;
    logic [63:0]         elapsed;
    logic [31:0]         len;
    logic                close;
    logic                sat;
    logic                div_start;
    t_div_req            div_req;
    t_div_stat           div_stat;
    t_div_req            req_rate, req_fill, req_pres;

    wfsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_req   (div_req),
        .o_stat  (div_stat)
    );

    assign slot_free = !r_out_valid || o_out.ready;

    always_comb begin
        mem_in    = i_cmd.mem_in_use[MW-1:0];
        vmem_in   = i_cmd.video_mem_in_use[MW-1:0];
        frames_nx = r_frames + 32'd1;
        elapsed   = i_cmd.timestamp_us - r_win_start;
        len       = (i_win_len == '0) ? 32'd1 : i_win_len;
        close     = (elapsed >= {32'b0, len}) && (frames_nx != '0);
        // rate >= 2^16 exactly when elapsed * 2^16 <= frames * 10^6
        sat       = (r_elapsed[63:36] == '0) && ({r_elapsed[35:0], 16'b0} <= r_prod);

        req_rate.rem     = {28'b0, r_prod[PROD_W-1:16]};
        req_rate.low     = {r_prod[15:0], 16'b0};
        req_rate.divisor = r_elapsed;
        req_rate.steps   = STEPS_RATE;
        req_fill.rem     = {32'b0, r_fill_sum[63:32]};
        req_fill.low     = r_fill_sum[31:0];
        req_fill.divisor = {32'b0, r_frames};
        req_fill.steps   = STEPS_MEAN;
        req_pres.rem     = {32'b0, r_pres_sum[63:32]};
        req_pres.low     = r_pres_sum[31:0];
        req_pres.divisor = {32'b0, r_frames};
        req_pres.steps   = STEPS_MEAN;
    end

    always_comb begin
        n_state      = r_state;
        n_win_start  = r_win_start;
        n_fill_sum   = r_fill_sum;
        n_pres_sum   = r_pres_sum;
        n_frames     = r_frames;
        n_mem_last   = r_mem_last;
        n_vmem_last  = r_vmem_last;
        n_mem_high   = r_mem_high;
        n_vmem_high  = r_vmem_high;
        n_fill_high  = r_fill_high;
        n_pres_high  = r_pres_high;
        n_rate       = r_rate;
        n_fill_mean  = r_fill_mean;
        n_pres_mean  = r_pres_mean;
        n_valid_flag = r_valid_flag;
        n_now        = r_now;
        n_elapsed    = r_elapsed;
        n_prod       = r_prod;
        n_out_valid  = r_out_valid && !o_out.ready;
        o_cmd_ready  = 1'b0;
        load_out     = 1'b0;
        done_bit     = 1'b0;
        div_start    = 1'b0;
        div_req      = req_fill;

        unique case (r_state)
            ST_IDLE: begin
                o_cmd_ready = slot_free;
                if (i_cmd_valid && slot_free) begin
                    unique case (i_cmd.op)
                        OP_RESTART: begin
                            n_win_start  = i_cmd.timestamp_us;
                            n_fill_sum   = '0;
                            n_pres_sum   = '0;
                            n_frames     = '0;
                            n_mem_last   = '0;
                            n_vmem_last  = '0;
                            n_mem_high   = '0;
                            n_vmem_high  = '0;
                            n_fill_high  = '0;
                            n_pres_high  = '0;
                            n_rate       = '0;
                            n_fill_mean  = '0;
                            n_pres_mean  = '0;
                            n_valid_flag = 1'b0;
                            load_out     = 1'b1;
                        end
                        OP_FRAME: begin
                            n_mem_last  = mem_in;
                            n_vmem_last = vmem_in;
                            if (mem_in > r_mem_high) begin
                                n_mem_high = mem_in;
                            end
                            if (vmem_in > r_vmem_high) begin
                                n_vmem_high = vmem_in;
                            end
                            if (i_cmd.fill_time_us > r_fill_high) begin
                                n_fill_high = i_cmd.fill_time_us;
                            end
                            if (i_cmd.present_time_us > r_pres_high) begin
                                n_pres_high = i_cmd.present_time_us;
                            end
                            n_fill_sum = r_fill_sum + {32'b0, i_cmd.fill_time_us};
                            n_pres_sum = r_pres_sum + {32'b0, i_cmd.present_time_us};
                            n_frames   = frames_nx;
                            if (close) begin
                                n_now     = i_cmd.timestamp_us;
                                n_elapsed = elapsed;
                                n_state   = ST_MUL;
                            end else begin
                                load_out = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MUL: begin
                n_prod  = PROD_W'(r_frames) * PROD_W'(USEC_PER_SEC);
                n_state = ST_SAT;
            end
            ST_SAT: begin
                div_start = 1'b1;
                if (sat) begin
                    n_rate  = RATE_MAX;
                    div_req = req_fill;
                    n_state = ST_FILL;
                end else begin
                    div_req = req_rate;
                    n_state = ST_RATE;
                end
            end
            ST_RATE: begin
                if (div_stat.done) begin
                    n_rate    = div_stat.quot[RATE_W-1:0];
                    div_start = 1'b1;
                    div_req   = req_fill;
                    n_state   = ST_FILL;
                end
            end
            ST_FILL: begin
                if (div_stat.done) begin
                    n_fill_mean = div_stat.quot;
                    div_start   = 1'b1;
                    div_req     = req_pres;
                    n_state     = ST_PRES;
                end
            end
            ST_PRES: begin
                if (div_stat.done) begin
                    n_pres_mean = div_stat.quot;
                    n_state     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_valid_flag = 1'b1;
                    n_win_start  = r_now;
                    n_fill_sum   = '0;
                    n_pres_sum   = '0;
                    n_frames     = '0;
                    load_out     = 1'b1;
                    done_bit     = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out = r_out;
        if (load_out) begin
            n_out_valid             = 1'b1;
            n_out.mem_current       = MEM_PORT_W'(n_mem_last);
            n_out.video_mem_current = MEM_PORT_W'(n_vmem_last);
            n_out.mem_peak          = MEM_PORT_W'(n_mem_high);
            n_out.video_mem_peak    = MEM_PORT_W'(n_vmem_high);
            n_out.fill_time_peak    = n_fill_high;
            n_out.present_time_peak = n_pres_high;
            n_out.frame_rate        = n_rate;
            n_out.fill_time_avg     = n_fill_mean;
            n_out.present_time_avg  = n_pres_mean;
            n_out.stats_valid       = n_valid_flag;
            n_out.window_done       = done_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_win_start  <= '0;
            r_fill_sum   <= '0;
            r_pres_sum   <= '0;
            r_frames     <= '0;
            r_mem_last   <= '0;
            r_vmem_last  <= '0;
            r_mem_high   <= '0;
            r_vmem_high  <= '0;
            r_fill_high  <= '0;
            r_pres_high  <= '0;
            r_rate       <= '0;
            r_fill_mean  <= '0;
            r_pres_mean  <= '0;
            r_valid_flag <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_win_start  <= n_win_start;
            r_fill_sum   <= n_fill_sum;
            r_pres_sum   <= n_pres_sum;
            r_frames     <= n_frames;
            r_mem_last   <= n_mem_last;
            r_vmem_last  <= n_vmem_last;
            r_mem_high   <= n_mem_high;
            r_vmem_high  <= n_vmem_high;
            r_fill_high  <= n_fill_high;
            r_pres_high  <= n_pres_high;
            r_rate       <= n_rate;
            r_fill_mean  <= n_fill_mean;
            r_pres_mean  <= n_pres_mean;
            r_valid_flag <= n_valid_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now     <= n_now;
        r_elapsed <= n_elapsed;
        r_prod    <= n_prod;
        r_out     <= n_out;
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.mem_current       = r_out.mem_current;
    assign o_out.video_mem_current = r_out.video_mem_current;
    assign o_out.mem_peak          = r_out.mem_peak;
    assign o_out.video_mem_peak    = r_out.video_mem_peak;
    assign o_out.fill_time_peak    = r_out.fill_time_peak;
    assign o_out.present_time_peak = r_out.present_time_peak;
    assign o_out.frame_rate        = r_out.frame_rate;
    assign o_out.fill_time_avg     = r_out.fill_time_avg;
    assign o_out.present_time_avg  = r_out.present_time_avg;
    assign o_out.stats_valid       = r_out.stats_valid;
    assign o_out.window_done       = r_out.window_done;

`ifndef ASSERT_OFF
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == ST_RATE || r_state == ST_FILL || r_state == ST_PRES))
        else $error("divider result arrived outside a division state");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && slot_free) |=> (r_frames == '0 && r_valid_flag && r_out_valid))
        else $error("window close did not reset the window");

    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.window_done) |-> r_out.stats_valid)
        else $error("closed window reported without stats_valid");
`endif

endmodule

`default_nettype wire

>>> hdl/windowed_frame_stats_monitor_top.sv
`default_nettype none

// Windowed frame statistics monitor. Each request on i_in is one frame record
// (kind 1) or a restart (kind 0); each yields exactly one snapshot on o_out.
// Requests enter a two-entry queue, so the source keeps going while the
// output waits. A restart or a frame that does not close the window is
// handled directly in the execution stage. A frame that closes the window
// first forms the frames * 10^6 product, then runs the saturation check,
// then a shared divider producing one quotient bit per cycle runs 16 steps
// for the rate (skipped when the frame rate saturates at 65535) and 32 steps
// for each of the two means. i_cfg writes window_length_us (reset 1000000;
// 0 acts as 1) and is always ready; write it only while the block is idle.
module windowed_frame_stats_monitor_top #(
    parameter int MEM_COUNT_BITS = 48
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    wfsm_in_if.sink     i_in,
    wfsm_cfg_if.sink    i_cfg,
    wfsm_out_if.source  o_out
);
    import wfsm_pkg::*;

    logic [31:0] r_win_len;
    logic        cmd_valid;
    logic        cmd_ready;
    t_cmd        cmd;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= WIN_LEN_RESET;
        end else if (i_cfg.valid) begin
            r_win_len <= i_cfg.data;
        end
    end

    wfsm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    wfsm_back #(
        .MEM_COUNT_BITS (MEM_COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_win_len   (r_win_len),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`default_nettype none

module tb_top;
    import wfsm_pkg::*;

    localparam int SETTLE_CYCLES = 120;
    localparam int LONG_HOLD     = 400;
    localparam int ITEMS_PER_LEN = 230;
    localparam int N_LENS        = 7;

    typedef struct packed {
        logic [47:0] mem_current;
        logic [47:0] video_mem_current;
        logic [47:0] mem_peak;
        logic [47:0] video_mem_peak;
        logic [31:0] fill_time_peak;
        logic [31:0] present_time_peak;
        logic [15:0] frame_rate;
        logic [31:0] fill_time_avg;
        logic [31:0] present_time_avg;
        logic        stats_valid;
        logic        window_done;
    } t_snapshot;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_mode;

    logic clk;
    logic rst_n;

    wfsm_in_if  in_if();
    wfsm_cfg_if cfg_if();
    wfsm_out_if out_if();

    windowed_frame_stats_monitor_top #(
        .MEM_COUNT_BITS(48)
    ) i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_if),
        .i_cfg  (cfg_if),
        .o_out  (out_if)
    );

    t_cmd      frame_reqs[$];
    t_snapshot snapshots_due[$];

    // predictor state
    logic [31:0] win_len_cfg;
    logic [63:0] win_start;
    logic [63:0] fill_acc;
    logic [63:0] pres_acc;
    logic [31:0] frame_cnt;
    logic [47:0] mem_last;
    logic [47:0] vmem_last;
    logic [47:0] mem_high;
    logic [47:0] vmem_high;
    logic [31:0] fill_high;
    logic [31:0] pres_high;
    logic [15:0] rate_hold;
    logic [31:0] fill_mean;
    logic [31:0] pres_mean;
    logic        stats_ok;

    int mismatches  = 0;
    int n_requests  = 0;
    int n_restarts  = 0;
    int n_windows   = 0;
    int n_saturated = 0;
    int n_len_writes = 0;

    int burst_left;
    int gap_left;
    int hold_left;
    int mode_left;
    t_rx_mode rx_mode;
    logic long_hold_req  = 1'b0;
    logic long_hold_done;

    logic [63:0] now_us;
    logic [31:0] win_lens [N_LENS];

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic t_snapshot next_snapshot(input t_cmd c);
        t_snapshot   s;
        logic [63:0] len_eff;
        logic [63:0] elapsed;
        logic [63:0] rate_full;
        logic [63:0] quo;
        s = '0;
        if (c.op == OP_RESTART) begin
            win_start = c.timestamp_us;
            fill_acc  = '0;
            pres_acc  = '0;
            frame_cnt = '0;
            mem_last  = '0;
            vmem_last = '0;
            mem_high  = '0;
            vmem_high = '0;
            fill_high = '0;
            pres_high = '0;
            rate_hold = '0;
            fill_mean = '0;
            pres_mean = '0;
            stats_ok  = 1'b0;
            n_restarts++;
        end else begin
            len_eff = (win_len_cfg == '0) ? 64'd1 : {32'd0, win_len_cfg};
            mem_last  = c.mem_in_use;
            vmem_last = c.video_mem_in_use;
            if (c.mem_in_use > mem_high) mem_high = c.mem_in_use;
            if (c.video_mem_in_use > vmem_high) vmem_high = c.video_mem_in_use;
            if (c.fill_time_us > fill_high) fill_high = c.fill_time_us;
            if (c.present_time_us > pres_high) pres_high = c.present_time_us;
            fill_acc  = fill_acc + {32'd0, c.fill_time_us};
            pres_acc  = pres_acc + {32'd0, c.present_time_us};
            frame_cnt = frame_cnt + 32'd1;
            elapsed   = c.timestamp_us - win_start;
            // a wrapped frame counter keeps the window open
            if (elapsed >= len_eff && frame_cnt != '0) begin
                rate_full = ({32'd0, frame_cnt} * {44'd0, USEC_PER_SEC}) / elapsed;
                if (rate_full > {48'd0, RATE_MAX}) begin
                    rate_hold = RATE_MAX;
                    n_saturated++;
                end else begin
                    rate_hold = rate_full[15:0];
                end
                quo = fill_acc / {32'd0, frame_cnt};
                fill_mean = quo[31:0];
                quo = pres_acc / {32'd0, frame_cnt};
                pres_mean = quo[31:0];
                stats_ok  = 1'b1;
                win_start = c.timestamp_us;
                fill_acc  = '0;
                pres_acc  = '0;
                frame_cnt = '0;
                s.window_done = 1'b1;
                n_windows++;
            end
        end
        s.mem_current       = mem_last;
        s.video_mem_current = vmem_last;
        s.mem_peak          = mem_high;
        s.video_mem_peak    = vmem_high;
        s.fill_time_peak    = fill_high;
        s.present_time_peak = pres_high;
        s.frame_rate        = rate_hold;
        s.fill_time_avg     = fill_mean;
        s.present_time_avg  = pres_mean;
        s.stats_valid       = stats_ok;
        return s;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] rand_word32();
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2: begin
                return $urandom_range(0, 1000);
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    function automatic logic [47:0] rand_mem48();
        logic [63:0] r;
        r = rand64();
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2: begin
                return {16'd0, r[31:0]};
            end
            default: begin
                return r[47:0];
            end
        endcase
    endfunction

    task automatic add_request(input t_op op, input logic [63:0] ts,
                               input logic [31:0] fill, input logic [31:0] pres,
                               input logic [47:0] mem, input logic [47:0] vmem);
        t_cmd c;
        c.op               = op;
        c.timestamp_us     = ts;
        c.fill_time_us     = fill;
        c.present_time_us  = pres;
        c.mem_in_use       = mem;
        c.video_mem_in_use = vmem;
        frame_reqs.push_back(c);
    endtask

    task automatic add_rand_frame(input logic [63:0] ts);
        add_request(OP_FRAME, ts, rand_word32(), rand_word32(), rand_mem48(),
                    rand_mem48());
    endtask

    task automatic drain_and_settle();
        while (frame_reqs.size() != 0 || in_if.valid || snapshots_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window_length(input logic [31:0] len);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= len;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        n_len_writes++;
    endtask

    // mostly runs of frames paced against the window length, plus strays
    task automatic gen_random_run(input logic [31:0] len, input int n);
        int          made;
        int          k;
        logic [63:0] len_eff;
        logic [63:0] step;
        logic [63:0] d;
        made    = 0;
        len_eff = (len == '0) ? 64'd1 : {32'd0, len};
        while (made < n) begin
            case ($urandom_range(0, 11))
                0: begin
                    add_rand_frame(rand64());
                    made++;
                end
                1: begin
                    if ($urandom_range(0, 1) == 0) now_us = rand64();
                    add_request(OP_RESTART, now_us, rand_word32(), rand_word32(),
                                rand_mem48(), rand_mem48());
                    made++;
                end
                2: begin
                    now_us = now_us - len_eff / $urandom_range(1, 4) - 64'd1;
                    add_rand_frame(now_us);
                    made++;
                end
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        add_request(OP_RESTART, now_us, rand_word32(), rand_word32(),
                                    rand_mem48(), rand_mem48());
                        made++;
                    end
                    k = $urandom_range(1, 16);
                    repeat (k) begin
                        step = len_eff / $urandom_range(1, 8);
                        if (step == '0) step = 64'd1;
                        if ($urandom_range(0, 15) == 0)
                            d = '0;
                        else
                            d = step + ($urandom % (step / 4 + 64'd1));
                        now_us = now_us + d;
                        add_rand_frame(now_us);
                        made++;
                    end
                end
            endcase
        end
    endtask

    // request driver
    always @(posedge clk) begin : drive_requests
        t_cmd c;
        t_cmd seen;
        if (!rst_n) begin
            in_if.valid <= 1'b0;
            burst_left  <= 0;
            gap_left    <= 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                seen.op               = t_op'(in_if.kind);
                seen.timestamp_us     = in_if.timestamp_us;
                seen.fill_time_us     = in_if.fill_time_us;
                seen.present_time_us  = in_if.present_time_us;
                seen.mem_in_use       = in_if.mem_in_use;
                seen.video_mem_in_use = in_if.video_mem_in_use;
                snapshots_due.push_back(next_snapshot(seen));
                n_requests++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (gap_left != 0) begin
                    gap_left    <= gap_left - 1;
                    in_if.valid <= 1'b0;
                end else if (frame_reqs.size() != 0) begin
                    c = frame_reqs.pop_front();
                    in_if.valid            <= 1'b1;
                    in_if.kind             <= c.op;
                    in_if.timestamp_us     <= c.timestamp_us;
                    in_if.fill_time_us     <= c.fill_time_us;
                    in_if.present_time_us  <= c.present_time_us;
                    in_if.mem_in_use       <= c.mem_in_use;
                    in_if.video_mem_in_use <= c.video_mem_in_use;
                    if (burst_left <= 1) begin
                        if ($urandom_range(0, 7) == 0) begin
                            burst_left <= 200;
                            gap_left   <= 0;
                        end else begin
                            burst_left <= $urandom_range(1, 24);
                            gap_left   <= $urandom_range(0, 6);
                        end
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // output backpressure
    always @(posedge clk) begin
        if (!rst_n) begin
            out_if.ready   <= 1'b0;
            hold_left      <= 0;
            mode_left      <= 0;
            rx_mode        <= RX_OPEN;
            long_hold_done <= 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            hold_left      <= LONG_HOLD;
            long_hold_done <= 1'b1;
            out_if.ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= t_rx_mode'($urandom_range(0, 3));
                mode_left <= $urandom_range(20, 300);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_OPEN: begin
                    out_if.ready <= 1'b1;
                end
                RX_COIN: begin
                    out_if.ready <= 1'($urandom_range(0, 1));
                end
                RX_SPARSE: begin
                    out_if.ready <= ($urandom_range(0, 7) == 0);
                end
                default: begin
                    out_if.ready <= (mode_left % 5 != 0);
                end
            endcase
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            win_len_cfg <= WIN_LEN_RESET;
        end else if (cfg_if.valid && cfg_if.ready) begin
            win_len_cfg <= cfg_if.data;
        end
    end

    always @(posedge clk) begin : check_snapshots
        t_snapshot want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (snapshots_due.size() == 0) begin
                $error("snapshot arrived with no request outstanding");
                mismatches++;
            end else begin
                want = snapshots_due.pop_front();
                check_field("mem_current", want.mem_current, out_if.mem_current);
                check_field("video_mem_current", want.video_mem_current,
                            out_if.video_mem_current);
                check_field("mem_peak", want.mem_peak, out_if.mem_peak);
                check_field("video_mem_peak", want.video_mem_peak, out_if.video_mem_peak);
                check_field("fill_time_peak", want.fill_time_peak, out_if.fill_time_peak);
                check_field("present_time_peak", want.present_time_peak,
                            out_if.present_time_peak);
                check_field("frame_rate", want.frame_rate, out_if.frame_rate);
                check_field("fill_time_avg", want.fill_time_avg, out_if.fill_time_avg);
                check_field("present_time_avg", want.present_time_avg,
                            out_if.present_time_avg);
                check_field("stats_valid", want.stats_valid, out_if.stats_valid);
                check_field("window_done", want.window_done, out_if.window_done);
            end
        end
    end

    initial begin
        rst_n                  = 1'b0;
        in_if.valid            = 1'b0;
        in_if.kind             = OP_RESTART;
        in_if.timestamp_us     = '0;
        in_if.fill_time_us     = '0;
        in_if.present_time_us  = '0;
        in_if.mem_in_use       = '0;
        in_if.video_mem_in_use = '0;
        cfg_if.valid           = 1'b0;
        cfg_if.data            = '0;
        out_if.ready           = 1'b0;
        now_us                 = '0;
        // predictor starts from the reset state
        win_start = '0;
        fill_acc  = '0;
        pres_acc  = '0;
        frame_cnt = '0;
        mem_last  = '0;
        vmem_last = '0;
        mem_high  = '0;
        vmem_high = '0;
        fill_high = '0;
        pres_high = '0;
        rate_hold = '0;
        fill_mean = '0;
        pres_mean = '0;
        stats_ok  = 1'b0;
        win_lens[0] = 32'd1;
        win_lens[1] = 32'd0;
        win_lens[2] = 32'hFFFF_FFFF;
        win_lens[3] = 32'd16667;
        win_lens[4] = WIN_LEN_RESET;
        win_lens[5] = $urandom_range(2, 5000);
        win_lens[6] = 32'd250000;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // default window length straight out of reset
        add_request(OP_FRAME, 64'd0, '0, '0, '0, '0);
        add_request(OP_FRAME, 64'd999_999, '1, '1, '1, '1);
        add_request(OP_FRAME, 64'd1_000_000, 32'd5, 32'd7, 48'd1, 48'd2);
        add_request(OP_RESTART, 64'hFFFF_FFFF_FFFF_FFF0, '1, '1, '1, '1);
        // window spans the 64-bit timestamp wrap
        add_request(OP_FRAME, 64'd999_984, 32'd100, 32'd200, 48'h8000_0000_0000, 48'd1);
        add_request(OP_FRAME, 64'd999_985, 32'd1, 32'd2, 48'd3, 48'd4);
        // timestamp going backwards reads as a huge elapsed time
        add_request(OP_FRAME, 64'd10, 32'd9, 32'd9, 48'd9, 48'd9);
        add_request(OP_RESTART, 64'd0, '0, '0, '0, '0);
        drain_and_settle();

        write_window_length(32'd1);
        add_request(OP_RESTART, 64'd100, '1, '0, '1, '0);
        add_request(OP_FRAME, 64'd101, 32'd3, 32'd4, 48'd5, 48'd6);
        add_request(OP_FRAME, 64'd101, 32'd3, 32'd4, 48'd5, 48'd6);
        add_request(OP_FRAME, 64'd102, 32'd8, 32'd1, 48'd2, 48'd7);
        drain_and_settle();

        // zero length behaves as one; then rate just above and below saturation
        write_window_length(32'd0);
        add_request(OP_FRAME, 64'd102, 32'd1, 32'd1, 48'd1, 48'd1);
        add_request(OP_FRAME, 64'd103, 32'd2, 32'd2, 48'd2, 48'd2);
        add_request(OP_FRAME, 64'd118, 32'd3, 32'd3, 48'd3, 48'd3);
        add_request(OP_FRAME, 64'd134, 32'd4, 32'd4, 48'd4, 48'd4);
        drain_and_settle();

        write_window_length(32'hFFFF_FFFF);
        add_request(OP_RESTART, 64'd0, '0, '0, '0, '0);
        add_request(OP_FRAME, 64'h0000_0000_FFFF_FFFE, '1, '1, '1, '1);
        add_request(OP_FRAME, 64'h0000_0000_FFFF_FFFF, '1, '1, '1, '1);
        add_request(OP_FRAME, 64'hFFFF_FFFF_FFFF_FFFF, '0, '1, '0, '1);
        drain_and_settle();

        for (int i = 0; i < N_LENS; i++) begin
            write_window_length(win_lens[i]);
            now_us = rand64();
            gen_random_run(win_lens[i], ITEMS_PER_LEN);
            if (i == 0) long_hold_req = 1'b1;
            drain_and_settle();
        end

        if (snapshots_due.size() != 0) begin
            $error("%0d snapshots never arrived", snapshots_due.size());
            mismatches++;
        end
        $display("Checked %0d requests (%0d restarts), %0d window closes, %0d saturated rates",
                 n_requests, n_restarts, n_windows, n_saturated);
        $display("over %0d window-length writes, incl. 0, 1 and 2^32-1, and one long hold-off",
                 n_len_writes);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
